[hw/rtl/xcfr_pkg.sv]
`default_nettype none

package xcfr_pkg;

    localparam int MaxFrame = 16;
    localparam int HeadLen  = 3;
    localparam int TailLen  = 2;
    localparam int OutCap   = 16;

    localparam int FillW = $clog2(MaxFrame + 1);
    localparam int AddrW = $clog2(MaxFrame);

    localparam int StoreLim = MaxFrame - HeadLen - TailLen;
    localparam int OutLim   = OutCap - HeadLen - TailLen;
    localparam int LenLim   = (StoreLim < OutLim) ? StoreLim : OutLim;
    localparam logic [3:0] LenCap = 4'(LenLim);

    localparam logic [1:0] RegStart  = 2'd0;
    localparam logic [1:0] RegEnd    = 2'd1;
    localparam logic [1:0] RegMaxLen = 2'd2;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [3:0] max_len;
    } t_cfg;

    typedef struct packed {
        logic             en;
        logic [AddrW-1:0] addr;
        logic [7:0]       data;
    } t_wr;

    typedef struct packed {
        logic             go;
        logic [FillW-1:0] cnt;
    } t_start;

endpackage

`default_nettype wire

[hw/rtl/xcfr_cfg.sv]
`default_nettype none

module xcfr_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output xcfr_pkg::t_cfg o_cfg
);
    import xcfr_pkg::*;

    logic [1:0] reg_idx;
    logic       wr_en;
    logic [7:0] r_start;
    logic [7:0] r_end;
    logic [3:0] r_max_len;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= 8'd170;
            r_end     <= 8'd85;
            r_max_len <= 4'd10;
        end else if (wr_en) begin
            case (reg_idx)
                RegStart:  r_start   <= pwdata[7:0];
                RegEnd:    r_end     <= pwdata[7:0];
                RegMaxLen: r_max_len <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            RegStart:  prdata = {24'd0, r_start};
            RegEnd:    prdata = {24'd0, r_end};
            RegMaxLen: prdata = {28'd0, r_max_len};
            default:   prdata = 32'd0;
        endcase
    end

    assign o_cfg.start_marker = r_start;
    assign o_cfg.end_marker   = r_end;
    assign o_cfg.max_len      = r_max_len;

endmodule

`default_nettype wire

[hw/rtl/xcfr_parse.sv]
`default_nettype none

module xcfr_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  xcfr_pkg::t_cfg    i_cfg,
    output xcfr_pkg::t_wr     o_wr,
    output xcfr_pkg::t_start  o_start
);
    import xcfr_pkg::*;

    localparam logic [2:0] PhHunt    = 3'd0;
    localparam logic [2:0] PhType    = 3'd1;
    localparam logic [2:0] PhLen     = 3'd2;
    localparam logic [2:0] PhPayload = 3'd3;
    localparam logic [2:0] PhCheck   = 3'd4;
    localparam logic [2:0] PhEnd     = 3'd5;

    logic [2:0]       r_phase, n_phase;
    logic [FillW-1:0] r_fill, n_fill;
    logic [3:0]       r_len, n_len;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_check, n_check;
    logic [3:0]       limit;
    logic             store;
    logic [FillW-1:0] wr_pos;
    logic             room;

    assign limit = (i_cfg.max_len > LenCap) ? LenCap : i_cfg.max_len;
    assign room  = (wr_pos < FillW'(MaxFrame));

    always_comb begin
        n_phase = r_phase;
        n_fill  = r_fill;
        n_len   = r_len;
        n_xor   = r_xor;
        n_check = r_check;
        store   = 1'b0;
        wr_pos  = r_fill;
        o_start = '0;
        if (i_accept) begin
            case (r_phase)
                PhType: begin
                    store   = 1'b1;
                    n_xor   = r_xor ^ i_byte;
                    n_phase = PhLen;
                end
                PhLen: begin
                    if (i_byte > {4'd0, limit}) begin
                        n_phase = PhHunt;
                    end else begin
                        store   = 1'b1;
                        n_xor   = r_xor ^ i_byte;
                        n_len   = i_byte[3:0];
                        n_phase = (i_byte != 8'd0) ? PhPayload : PhCheck;
                    end
                end
                PhPayload: begin
                    store = 1'b1;
                    n_xor = r_xor ^ i_byte;
                end
                PhCheck: begin
                    store   = 1'b1;
                    n_check = i_byte;
                    n_phase = PhEnd;
                end
                PhEnd: begin
                    store   = 1'b1;
                    n_phase = PhHunt;
                end
                default: begin
                    n_phase = PhHunt;
                    if (i_byte == i_cfg.start_marker) begin
                        store   = 1'b1;
                        wr_pos  = '0;
                        n_fill  = '0;
                        n_len   = '0;
                        n_check = '0;
                        n_xor   = i_byte;
                        n_phase = PhType;
                    end
                end
            endcase
            if (store && (wr_pos < FillW'(MaxFrame))) begin
                n_fill = wr_pos + 1'b1;
            end
            if (r_phase == PhPayload &&
                n_fill >= FillW'(HeadLen) + FillW'(r_len)) begin
                n_phase = PhCheck;
            end
            if (r_phase == PhEnd && i_byte == i_cfg.end_marker && r_check == r_xor) begin
                o_start.go  = 1'b1;
                o_start.cnt = (n_fill > FillW'(OutCap)) ? FillW'(OutCap) : n_fill;
            end
        end
    end

    assign o_wr.en   = store & room;
    assign o_wr.addr = wr_pos[AddrW-1:0];
    assign o_wr.data = i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PhHunt;
            r_fill  <= '0;
            r_len   <= '0;
            r_xor   <= '0;
            r_check <= '0;
        end else begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_xor   <= n_xor;
            r_check <= n_check;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/xcfr_replay.sv]
`default_nettype none

module xcfr_replay (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xcfr_pkg::t_wr     i_wr,
    input  xcfr_pkg::t_start  i_start,
    input  logic              i_out_ready,
    output logic              o_busy,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic [3:0]        o_out_pos,
    output logic              o_out_last
);
    import xcfr_pkg::*;

    logic [7:0]       mem [MaxFrame];
    logic [7:0]       r_rdata;
    logic             r_active, n_active;
    logic [FillW-1:0] r_idx, n_idx;
    logic [FillW-1:0] r_cnt;
    logic             r_pend, n_pend;
    logic [FillW-1:0] r_pos;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic [3:0]       r_out_pos;
    logic             r_out_last;
    logic             out_free;
    logic             load;
    logic             issue;

    assign out_free = !r_out_valid || i_out_ready;
    assign load     = r_pend && out_free;
    assign issue    = r_active && (r_idx < r_cnt) && (!r_pend || load);

    always_comb begin
        n_idx    = issue ? r_idx + 1'b1 : r_idx;
        n_pend   = issue | (r_pend & ~load);
        n_active = r_active && !(n_idx == r_cnt && !n_pend);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (issue) begin
            r_rdata <= mem[r_idx[AddrW-1:0]];
            r_pos   <= r_idx;
        end
        if (load) begin
            r_out_byte <= r_rdata;
            r_out_pos  <= r_pos[3:0];
            r_out_last <= (r_pos + 1'b1 == r_cnt);
        end
        if (i_start.go) begin
            r_cnt <= i_start.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_start.go) begin
                r_active <= 1'b1;
                r_idx    <= '0;
                r_pend   <= 1'b0;
            end else begin
                r_active <= n_active;
                r_idx    <= n_idx;
                r_pend   <= n_pend;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_busy      = r_active;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_pos   = r_out_pos;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

[hw/rtl/xor_checked_frame_receiver.sv]
// Channel   Dir  Payload                                        Transfer
// s_axis    in   tdata[7:0] rx_byte                             tvalid & tready
// m_axis    out  tdata[7:0] frame_byte, [11:8] byte_position;   tvalid & tready
//                tlast last_byte
// apb       in   regs 0x0 start_marker, 0x4 end_marker,         psel&penable&pwrite
//                0x8 max_payload_len
//
// Receive: one byte per cycle while no frame replays; each frame byte is written to the
// frame buffer in the same cycle. Replay: after a good end marker, one stored byte per
// cycle while m_axis is ready, via a buffer read register; input is blocked meanwhile.
// Reset is synchronous, active low; the frame buffer holds no reset value.
// A stalled m_axis holds the output register and the replay; s_axis reopens as soon
// as the last byte sits in the output register.
`default_nettype none

module xor_checked_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] frame_byte, [11:8] byte_position, zeros
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import xcfr_pkg::*;

    t_cfg       cfg;
    t_wr        wr;
    t_start     start;
    logic       busy;
    logic       accept;
    logic [7:0] out_byte;
    logic [3:0] out_pos;

    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid & s_axis_tready;

    xcfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    xcfr_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_cfg    (cfg),
        .o_wr     (wr),
        .o_start  (start)
    );

    xcfr_replay u_replay (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_start     (start),
        .i_out_ready (m_axis_tready),
        .o_busy      (busy),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (out_byte),
        .o_out_pos   (out_pos),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, out_pos, out_byte};

endmodule

`default_nettype wire

[hw/rtl/xcfr_checker.sv]
`default_nettype none

module xcfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0)
        else $error("m_axis padding bits not zero");

    a_replay_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open while a frame is still replaying");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[11:8] >= 4'd4)
        else $error("frame closed shorter than the minimum frame");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled m_axis transfer changed");

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[tb/sv/xor_checked_frame_receiver_test.sv]
`default_nettype none

module xor_checked_frame_receiver_test;

    import xcfr_pkg::*;

    typedef enum logic [2:0] {
        RX_HUNT, RX_TYPE, RX_LEN, RX_BODY, RX_CHECK, RX_END
    } t_rx_phase;

    typedef enum logic [2:0] {
        FLAW_NONE, FLAW_CHECK, FLAW_END, FLAW_LONG, FLAW_CUT
    } t_frame_flaw;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] pos;
        logic       last;
    } t_frame_beat;

    localparam int StallLimit = 3000;
    localparam int LongHold   = 300;
    localparam int SettleCyc  = 24;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] frame_byte, [11:8] byte_position, zeros
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    xor_checked_frame_receiver i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // register copy
    logic [7:0] cfg_start = 8'd170;
    logic [7:0] cfg_end = 8'd85;
    logic [3:0] cfg_max_len = 4'd10;

    // receiver state copy
    t_rx_phase  rx_phase = RX_HUNT;
    logic [7:0] rx_store [MaxFrame];
    int         rx_fill = 0;
    logic [7:0] rx_len = 8'd0;
    logic [7:0] rx_xor = 8'd0;
    logic [7:0] rx_check = 8'd0;

    logic [7:0]  rx_pending[$];
    t_frame_beat frame_beats_due[$];

    bit idle_on = 1'b1;
    bit long_hold_req = 1'b0;
    int src_gap = 0;
    int sink_hold = 0;
    int stall_cycles = 0;
    int errors = 0;
    int bytes_in = 0;
    int frames_out = 0;
    int beats_out = 0;
    int settings = 1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic keep_rx_byte(input logic [7:0] b);
        if (rx_fill < MaxFrame) begin
            rx_store[rx_fill] = b;
            rx_fill++;
        end
    endtask

    task automatic absorb_rx_byte(input logic [7:0] b);
        logic [3:0] lim;
        int cnt;
        lim = (cfg_max_len > LenCap) ? LenCap : cfg_max_len;
        case (rx_phase)
            RX_TYPE: begin
                keep_rx_byte(b);
                rx_xor ^= b;
                rx_phase = RX_LEN;
            end
            RX_LEN: begin
                if (b > {4'h0, lim}) begin
                    rx_phase = RX_HUNT;
                end else begin
                    keep_rx_byte(b);
                    rx_xor ^= b;
                    rx_len = b;
                    rx_phase = (b != 8'd0) ? RX_BODY : RX_CHECK;
                end
            end
            RX_BODY: begin
                keep_rx_byte(b);
                rx_xor ^= b;
                if (rx_fill >= HeadLen + int'(rx_len)) rx_phase = RX_CHECK;
            end
            RX_CHECK: begin
                keep_rx_byte(b);
                rx_check = b;
                rx_phase = RX_END;
            end
            RX_END: begin
                keep_rx_byte(b);
                rx_phase = RX_HUNT;
                if (b == cfg_end && rx_check == rx_xor) begin
                    cnt = (rx_fill > OutCap) ? OutCap : rx_fill;
                    for (int i = 0; i < cnt; i++) begin
                        frame_beats_due.push_back({rx_store[i], 4'(i), i + 1 == cnt});
                    end
                    frames_out++;
                end
            end
            default: begin
                rx_phase = RX_HUNT;
                if (b == cfg_start) begin
                    rx_fill = 0;
                    rx_len = 8'd0;
                    rx_check = 8'd0;
                    keep_rx_byte(b);
                    rx_xor = b;
                    rx_phase = RX_TYPE;
                end
            end
        endcase
    endtask

    task automatic queue_frame(input int len, input t_frame_flaw flaw, input bit extreme_fill);
        logic [7:0] sum;
        logic [7:0] b;
        sum = cfg_start;
        rx_pending.push_back(cfg_start);
        b = extreme_fill ? 8'h00 : 8'($urandom);
        rx_pending.push_back(b);
        sum ^= b;
        rx_pending.push_back(8'(len));
        if (flaw == FLAW_LONG) return;
        sum ^= 8'(len);
        for (int i = 0; i < len; i++) begin
            b = extreme_fill ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
            rx_pending.push_back(b);
            sum ^= b;
        end
        if (flaw == FLAW_CUT) return;
        rx_pending.push_back(flaw == FLAW_CHECK ? sum ^ (8'h01 << $urandom_range(0, 7)) : sum);
        if (flaw == FLAW_END) begin
            rx_pending.push_back(cfg_start != cfg_end ? cfg_start : ~cfg_end);
        end else begin
            rx_pending.push_back(cfg_end);
        end
    endtask

    task automatic queue_noise(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (b == cfg_start && $urandom_range(0, 9) != 0) b = ~b;
            rx_pending.push_back(b);
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            RegStart: cfg_start = val[7:0];
            RegEnd:   cfg_end = val[7:0];
            default:  cfg_max_len = val[3:0];
        endcase
    endtask

    task automatic set_registers(input logic [7:0] sm, input logic [7:0] em, input logic [3:0] ml);
        apb_write(RegStart, {24'h0, sm});
        apb_write(RegEnd, {24'h0, em});
        apb_write(RegMaxLen, {28'h0, ml});
        settings++;
    endtask

    task automatic wait_quiet();
        while (rx_pending.size() != 0 || s_axis_tvalid || frame_beats_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCyc) @(posedge i_clk);
    endtask

    function automatic int len_limit();
        return (cfg_max_len > LenCap) ? int'(LenCap) : int'(cfg_max_len);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (rx_pending.size() != 0 && idle_on && $urandom_range(0, 4) == 0) begin
                src_gap = $urandom_range(0, 8);
                s_axis_tvalid <= 1'b0;
            end else if (rx_pending.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= rx_pending.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            sink_hold = LongHold;
            m_axis_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            sink_hold = $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        t_frame_beat want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            absorb_rx_byte(s_axis_tdata);
            bytes_in++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            if (frame_beats_due.size() == 0) begin
                $error("unexpected frame byte %0h at position %0d",
                       m_axis_tdata[7:0], m_axis_tdata[11:8]);
                errors++;
            end else begin
                want = frame_beats_due.pop_front();
                if (m_axis_tdata[7:0] !== want.data) begin
                    $error("frame_byte expected %0h got %0h", want.data, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[11:8] !== want.pos) begin
                    $error("byte_position expected %0d got %0d", want.pos, m_axis_tdata[11:8]);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_byte expected %0b got %0b", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= StallLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int rand_items;
        int lim;
        int r;
        t_frame_flaw flaw;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values
        queue_frame(0, FLAW_NONE, 1'b0);
        queue_frame(1, FLAW_END, 1'b0);
        queue_frame(2, FLAW_NONE, 1'b1);
        queue_frame(11, FLAW_LONG, 1'b0);
        queue_noise(2);
        queue_frame(len_limit(), FLAW_NONE, 1'b0);
        wait_quiet();

        set_registers(8'h00, 8'hFF, 4'd0);
        queue_frame(0, FLAW_NONE, 1'b1);
        queue_frame(1, FLAW_LONG, 1'b0);
        queue_frame(0, FLAW_CHECK, 1'b0);
        wait_quiet();

        set_registers(8'hFF, 8'h00, 4'd15);
        queue_frame(11, FLAW_NONE, 1'b1);
        queue_frame(12, FLAW_LONG, 1'b0);
        queue_frame(255, FLAW_LONG, 1'b0);
        queue_frame(5, FLAW_CUT, 1'b0);
        queue_frame(3, FLAW_NONE, 1'b0);
        wait_quiet();

        rand_items = bytes_in;
        for (int ph = 0; rand_items < 200; ph++) begin
            idle_on = (rand_items < 160) ? ($urandom_range(0, 3) != 0) : 1'b0;
            set_registers(8'($urandom), 8'($urandom), 4'($urandom));
            lim = len_limit();
            r = rx_pending.size();
            for (int f = 0; f < 6; f++) begin
                case ($urandom_range(0, 9))
                    0:       flaw = FLAW_CHECK;
                    1:       flaw = FLAW_END;
                    2:       flaw = FLAW_CUT;
                    3:       flaw = (lim < 255) ? FLAW_LONG : FLAW_NONE;
                    default: flaw = FLAW_NONE;
                endcase
                if (flaw == FLAW_LONG) begin
                    queue_frame($urandom_range(lim + 1, 255), flaw, 1'b0);
                end else begin
                    queue_frame($urandom_range(0, lim), flaw, 1'b0);
                end
                if ($urandom_range(0, 2) == 0) queue_noise($urandom_range(1, 3));
            end
            rand_items += rx_pending.size() - r;
            // hold the receiver while the sender keeps offering
            if (ph == 0) long_hold_req = 1'b1;
            wait_quiet();
        end

        $display("tb: %0d bytes sent under %0d register settings", bytes_in, settings);
        $display("tb: %0d frames replayed, %0d frame bytes checked", frames_out, beats_out);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
